>>> rtl/fpp_pkg.sv
package fpp_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int SUM_W   = FILL_W + 1;

  localparam int FUNC_W  = 3;
  localparam int TID_W   = 8;
  localparam int PIDX_W  = 16;
  localparam int KEY_W   = TID_W + PIDX_W;
  localparam int OSLOT_W = 6;
  localparam int COUNT_W = 7;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET        = 3'd0,
    FUNC_INSERT     = 3'd1,
    FUNC_UPDATE     = 3'd2,
    FUNC_UNLOAD     = 3'd3,
    FUNC_UNLOAD_ALL = 3'd4
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  table_id;
    logic [PIDX_W-1:0] page_index;
    logic              bypass_pool;
    logic [TID_W-1:0]  new_table_id;
    logic [PIDX_W-1:0] new_page_index;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [OSLOT_W-1:0] slot;
    logic               evicted;
    logic               evicted_valid;
    logic [TID_W-1:0]   evicted_table_id;
    logic [PIDX_W-1:0]  evicted_page_index;
    logic [COUNT_W-1:0] match_count;
  } result_t;

endpackage

>>> rtl/fifo_page_pool_tag_store_core.sv
// Tag store and FIFO replacement for a fully associative page pool of
// fpp_pkg::SLOTS entries keyed by (table id, page index). Every transfer on
// the input stream yields exactly one result transfer. An item is held in
// the input register, is compared against all entries in parallel there
// and lands in the result register, so the block takes one item per clock
// while the result side is not stalled; the parallel key compare and the
// oldest-first priority pick over all slots lie between the two registers.
// Back-pressure on the result side stalls the input register and then the input stream.
// Unload clears only the valid flag: the slot keeps its place in the FIFO
// order and is still evicted in turn.
module fifo_page_pool_tag_store_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // table_id, page_index, new_table_id, new_page_index
  input  logic [fpp_pkg::S_TDATA_W-1:0]  s_tdata,
  // func, bypass_pool
  input  logic [fpp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // slot, evicted_table_id, evicted_page_index, match_count, zero pad
  output logic [fpp_pkg::M_TDATA_W-1:0]  m_tdata,
  // hit, evicted, evicted_valid
  output logic [fpp_pkg::M_TUSER_W-1:0]  m_tuser
);

  localparam int SLOTS  = fpp_pkg::SLOTS;
  localparam int SLOT_W = fpp_pkg::SLOT_W;
  localparam int FILL_W = fpp_pkg::FILL_W;
  localparam int SUM_W  = fpp_pkg::SUM_W;
  localparam int KEY_W  = fpp_pkg::KEY_W;

  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(SLOTS)) begin
      sum = sum - SUM_W'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // input register
  logic           in_valid;
  fpp_pkg::item_t in_q;
  logic           adv;

  // pool state
  logic [KEY_W-1:0]  page_key [SLOTS];
  logic [SLOTS-1:0]  entry_valid;
  logic [SLOTS-1:0]  entry_valid_next;
  logic [SLOT_W-1:0] oldest_ptr;
  logic [SLOT_W-1:0] oldest_ptr_next;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;

  fpp_pkg::result_t res_q;
  fpp_pkg::result_t res_next;

  logic [KEY_W-1:0]          key;
  logic [KEY_W-1:0]          new_key;
  logic [SLOTS-1:0]          match;
  logic [SLOT_W-1:0]         age_slot [SLOTS];
  logic [SLOTS-1:0]          age_match;
  logic [SLOT_W-1:0]         hit_age;
  logic                      any_match;
  logic [SLOT_W-1:0]         hit_slot;
  logic                      full;
  logic [SLOT_W-1:0]         ins_slot;
  logic [fpp_pkg::COUNT_W-1:0] match_cnt;
  logic [fpp_pkg::COUNT_W-1:0] valid_cnt;
  logic                      do_insert;
  logic [SLOTS-1:0]          rekey;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.func           <= s_tuser[2:0];
      in_q.bypass_pool    <= s_tuser[3];
      in_q.table_id       <= s_tdata[7:0];
      in_q.page_index     <= s_tdata[23:8];
      in_q.new_table_id   <= s_tdata[31:24];
      in_q.new_page_index <= s_tdata[47:32];
    end
  end

  assign key     = {in_q.table_id, in_q.page_index};
  assign new_key = {in_q.new_table_id, in_q.new_page_index};
  assign full    = (fill_count == FILL_W'(SLOTS));
  assign ins_slot = full ? oldest_ptr : wrap_add(oldest_ptr, fill_count);

  // valid entries are always occupied, so no occupancy check is needed
  always_comb begin
    match_cnt = '0;
    valid_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = entry_valid[i] && (page_key[i] == key);
      match_cnt = match_cnt + fpp_pkg::COUNT_W'(match[i]);
      valid_cnt = valid_cnt + fpp_pkg::COUNT_W'(entry_valid[i]);
    end
  end

  // oldest-first pick: rotate the match vector by the queue head
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      age_slot[j]  = wrap_add(oldest_ptr, FILL_W'(j));
      age_match[j] = match[age_slot[j]];
    end
    hit_age = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (age_match[j]) begin
        hit_age = SLOT_W'(j);
      end
    end
    any_match = |match;
    hit_slot  = age_slot[hit_age];
  end

  always_comb begin
    res_next         = '0;
    do_insert        = 1'b0;
    rekey            = '0;
    entry_valid_next = entry_valid;
    oldest_ptr_next  = oldest_ptr;
    fill_count_next  = fill_count;
    unique case (in_q.func)
      fpp_pkg::FUNC_GET: begin
        if (!in_q.bypass_pool && any_match) begin
          res_next.hit  = 1'b1;
          res_next.slot = fpp_pkg::OSLOT_W'(hit_slot);
        end else begin
          do_insert = 1'b1;
        end
      end
      fpp_pkg::FUNC_INSERT: begin
        do_insert = 1'b1;
      end
      fpp_pkg::FUNC_UPDATE: begin
        rekey                = match;
        res_next.match_count = match_cnt;
      end
      fpp_pkg::FUNC_UNLOAD: begin
        entry_valid_next     = entry_valid & ~match;
        res_next.match_count = match_cnt;
      end
      fpp_pkg::FUNC_UNLOAD_ALL: begin
        entry_valid_next     = '0;
        res_next.match_count = valid_cnt;
      end
      default: begin
      end
    endcase
    if (do_insert) begin
      res_next.slot = fpp_pkg::OSLOT_W'(ins_slot);
      entry_valid_next[ins_slot] = 1'b1;
      if (full) begin
        res_next.evicted            = 1'b1;
        res_next.evicted_valid      = entry_valid[oldest_ptr];
        res_next.evicted_table_id   = page_key[oldest_ptr][KEY_W-1:fpp_pkg::PIDX_W];
        res_next.evicted_page_index = page_key[oldest_ptr][fpp_pkg::PIDX_W-1:0];
        oldest_ptr_next             = wrap_add(oldest_ptr, FILL_W'(1));
      end else begin
        fill_count_next = fill_count + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      oldest_ptr  <= '0;
      fill_count  <= '0;
    end else if (adv) begin
      entry_valid <= entry_valid_next;
      oldest_ptr  <= oldest_ptr_next;
      fill_count  <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (rekey[i]) begin
          page_key[i] <= new_key;
        end
      end
      if (do_insert) begin
        page_key[ins_slot] <= key;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign m_tdata = {3'b000, res_q.match_count, res_q.evicted_page_index,
                    res_q.evicted_table_id, res_q.slot};
  assign m_tuser = {res_q.evicted_valid, res_q.evicted, res_q.hit};

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(SLOTS))
    else $error("fill count above pool size");

  a_head_moves_when_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_ptr != '0) |-> full)
    else $error("queue head moved before pool filled");

  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (entry_valid == '0))
    else $error("valid entry in empty pool");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && m_tdata[36:30] == '0))
    else $error("hit result carries eviction or count");

  a_evict_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tuser[1])
    else $error("evicted_valid without eviction");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> (in_valid && $stable(in_q)))
    else $error("input register lost a stalled item");

endmodule
